FILE: rtl/core/sblc_pkg.sv
// sblc_pkg: shared types and constants of the size budget lru cache
// no dependencies; imported by the cache top level and the bench

package sblc_pkg;

  localparam int unsigned DEFAULT_ENTRIES = 16;
  localparam int unsigned KEY_W           = 32;
  localparam int unsigned SIZE_W          = 24;
  localparam int unsigned REC_W           = 32;
  localparam int unsigned BUDGET_W        = 32;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 32'd1048576;

  // result kind codes
  localparam logic KIND_EVICT = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  // one table entry as stored in the entry ram
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
    logic [REC_W-1:0]  rec;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_INSERT,
    ST_CHECK,
    ST_EVSCAN,
    ST_EVICT
  } sblc_state_e;

endpackage

FILE: rtl/core/sblc_ram.sv
// sblc_ram: generic single write port, single read port ram with registered read
// no dependencies; holds the key, size and recency of every cache entry

module sblc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/size_budget_lru_cache.sv
// size_budget_lru_cache: lru cache of keyed items weighted by size under a byte budget
// depends on sblc_pkg and sblc_ram (entry store)
//
//  channel   | ports                                           | handshake
//  ----------+-------------------------------------------------+------------------------------
//  request   | item_key_i, item_size_i                         | taken when start && !busy
//  result    | result_kind_o, evicted_key_o, was_hit_o,        | one cycle, result_valid_o
//            | last_result_o                                   |
//  config    | memory_budget_i                                 | written when memory_budget_we_i
//
//  a request scans the entry ram once for the lookup and once more for every budget
//  eviction; every scan walks the entry ram one entry a cycle through its single
//  read port, so the scans set how long a request takes
//  busy is high from the cycle after a request is taken; it drops in the cycle
//  that carries the last result
//  reset clears the valid bits, the recency counter, the used total and the budget
//  (to 1 MiB); the entry ram itself is not cleared, invalid entries are never used
//  results leave through an output register and cannot be stalled

module size_budget_lru_cache
  import sblc_pkg::*;
#(
  parameter int unsigned ENTRIES = DEFAULT_ENTRIES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request
  input  logic                start,
  output logic                busy,
  input  logic [KEY_W-1:0]    item_key_i,
  input  logic [SIZE_W-1:0]   item_size_i,
  // results
  output logic                result_valid_o,
  output logic                result_kind_o,
  output logic [KEY_W-1:0]    evicted_key_o,
  output logic                was_hit_o,
  output logic                last_result_o,
  // budget register
  input  logic                memory_budget_we_i,
  input  logic [BUDGET_W-1:0] memory_budget_i
);

  localparam int unsigned IW     = $clog2(ENTRIES);
  localparam int unsigned CW     = $clog2(ENTRIES + 1);
  localparam int unsigned USED_W = SIZE_W + $clog2(ENTRIES + 1);
  localparam int unsigned ENT_W  = $bits(entry_t);

  sblc_state_e state_q, state_d;

  // scan pointer: address issued this cycle, data of entry idx_q-1 arrives
  logic [CW-1:0]       idx_q, idx_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [SIZE_W-1:0]   size_q, size_d;
  logic [REC_W-1:0]    ctr_q, ctr_d;
  logic [USED_W-1:0]   used_q, used_d;
  logic [BUDGET_W-1:0] budget_q;
  logic [ENTRIES-1:0]  valid_q, valid_d;

  // request slot and scan results
  logic                hit_q, hit_d;
  logic [IW-1:0]       slot_q, slot_d;
  logic [SIZE_W-1:0]   slot_size_q, slot_size_d;
  logic                free_found_q, free_found_d;
  logic [IW-1:0]       free_slot_q, free_slot_d;
  logic                vic_found_q, vic_found_d;
  logic [IW-1:0]       vic_slot_q, vic_slot_d;
  logic [REC_W-1:0]    vic_age_q, vic_age_d;
  logic [KEY_W-1:0]    vic_key_q, vic_key_d;
  logic [SIZE_W-1:0]   vic_size_q, vic_size_d;

  // result register
  logic                res_valid_q, res_valid_d;
  logic                kind_q, kind_d;
  logic [KEY_W-1:0]    ekey_q, ekey_d;
  logic                rhit_q, rhit_d;
  logic                last_q, last_d;

  // entry ram port
  logic                ram_we, ram_re;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  entry_t              ram_wdata;
  logic [ENT_W-1:0]    ram_rdata;

  // entry under inspection during a scan
  entry_t              ent;
  logic [CW-1:0]       scan_j;
  logic [IW-1:0]       scan_jj;
  logic                ent_valid;
  logic [REC_W-1:0]    ent_age;
  logic                scan_last;
  logic                over_budget;

  sblc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ent         = entry_t'(ram_rdata);
  assign scan_j      = idx_q - CW'(1);
  assign scan_jj     = scan_j[IW-1:0];
  assign ent_valid   = valid_q[scan_jj];
  // age grows with staleness and stays ordered across counter wrap
  assign ent_age     = ctr_q - ent.rec;
  assign scan_last   = (idx_q == CW'(ENTRIES));
  assign over_budget = (BUDGET_W'(used_q) > budget_q);

  assign busy = (state_q != ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (scan_last) state_d = ST_INSERT;
      end
      ST_INSERT: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = over_budget ? ST_EVSCAN : ST_IDLE;
      end
      ST_EVSCAN: begin
        if (scan_last) state_d = ST_EVICT;
      end
      ST_EVICT: begin
        state_d = vic_found_q ? ST_CHECK : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath, ram control and result
  always_comb begin
    idx_d        = idx_q;
    key_d        = key_q;
    size_d       = size_q;
    ctr_d        = ctr_q;
    used_d       = used_q;
    valid_d      = valid_q;
    hit_d        = hit_q;
    slot_d       = slot_q;
    slot_size_d  = slot_size_q;
    free_found_d = free_found_q;
    free_slot_d  = free_slot_q;
    vic_found_d  = vic_found_q;
    vic_slot_d   = vic_slot_q;
    vic_age_d    = vic_age_q;
    vic_key_d    = vic_key_q;
    vic_size_d   = vic_size_q;
    res_valid_d  = 1'b0;
    kind_d       = kind_q;
    ekey_d       = ekey_q;
    rhit_d       = rhit_q;
    last_d       = last_q;
    ram_we       = 1'b0;
    ram_waddr    = slot_q;
    ram_wdata    = '{key: key_q, size: slot_size_q, rec: ctr_q};
    ram_re       = 1'b0;
    ram_raddr    = idx_q[IW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          key_d        = item_key_i;
          size_d       = item_size_i;
          ctr_d        = ctr_q + REC_W'(1);
          idx_d        = '0;
          hit_d        = 1'b0;
          free_found_d = 1'b0;
          vic_found_d  = 1'b0;
        end
      end

      ST_LOOKUP: begin
        ram_re = (idx_q < CW'(ENTRIES));
        idx_d  = idx_q + CW'(1);
        if (idx_q != '0) begin
          if (ent_valid && ent.key == key_q && !hit_q) begin
            hit_d       = 1'b1;
            slot_d      = scan_jj;
            slot_size_d = ent.size;
          end
          if (!ent_valid && !free_found_q) begin
            free_found_d = 1'b1;
            free_slot_d  = scan_jj;
          end
          // victim for a full table, ties to the lowest slot
          if (ent_valid && (!vic_found_q || ent_age > vic_age_q)) begin
            vic_found_d = 1'b1;
            vic_slot_d  = scan_jj;
            vic_age_d   = ent_age;
            vic_key_d   = ent.key;
            vic_size_d  = ent.size;
          end
        end
      end

      ST_INSERT: begin
        ram_we = 1'b1;
        if (hit_q) begin
          // restamp only
          ram_waddr = slot_q;
          ram_wdata = '{key: key_q, size: slot_size_q, rec: ctr_q};
        end else if (free_found_q) begin
          ram_waddr            = free_slot_q;
          ram_wdata            = '{key: key_q, size: size_q, rec: ctr_q};
          slot_d               = free_slot_q;
          slot_size_d          = size_q;
          valid_d[free_slot_q] = 1'b1;
          used_d               = used_q + USED_W'(size_q);
        end else begin
          // full table: the oldest entry gives up its slot
          ram_waddr   = vic_slot_q;
          ram_wdata   = '{key: key_q, size: size_q, rec: ctr_q};
          slot_d      = vic_slot_q;
          slot_size_d = size_q;
          used_d      = used_q - USED_W'(vic_size_q) + USED_W'(size_q);
          res_valid_d = 1'b1;
          kind_d      = KIND_EVICT;
          ekey_d      = vic_key_q;
          rhit_d      = 1'b0;
          last_d      = 1'b0;
        end
      end

      ST_CHECK: begin
        idx_d       = '0;
        vic_found_d = 1'b0;
        if (!over_budget) begin
          res_valid_d = 1'b1;
          kind_d      = KIND_FINAL;
          ekey_d      = '0;
          rhit_d      = hit_q;
          last_d      = 1'b1;
        end
      end

      ST_EVSCAN: begin
        ram_re = (idx_q < CW'(ENTRIES));
        idx_d  = idx_q + CW'(1);
        if (idx_q != '0) begin
          // the requested entry is never a candidate here
          if (ent_valid && scan_jj != slot_q &&
              (!vic_found_q || ent_age > vic_age_q)) begin
            vic_found_d = 1'b1;
            vic_slot_d  = scan_jj;
            vic_age_d   = ent_age;
            vic_key_d   = ent.key;
            vic_size_d  = ent.size;
          end
        end
      end

      ST_EVICT: begin
        res_valid_d = 1'b1;
        kind_d      = KIND_EVICT;
        if (vic_found_q) begin
          ekey_d              = vic_key_q;
          rhit_d              = 1'b0;
          last_d              = 1'b0;
          valid_d[vic_slot_q] = 1'b0;
          used_d              = used_q - USED_W'(vic_size_q);
        end else begin
          // only the requested entry is left: it goes and ends the request
          ekey_d          = key_q;
          rhit_d          = hit_q;
          last_d          = 1'b1;
          valid_d[slot_q] = 1'b0;
          used_d          = used_q - USED_W'(slot_size_q);
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      ctr_q        <= '0;
      used_q       <= '0;
      budget_q     <= BUDGET_RESET;
      valid_q      <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      vic_found_q  <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      ctr_q        <= ctr_d;
      used_q       <= used_d;
      valid_q      <= valid_d;
      hit_q        <= hit_d;
      free_found_q <= free_found_d;
      vic_found_q  <= vic_found_d;
      res_valid_q  <= res_valid_d;
      if (memory_budget_we_i) begin
        budget_q <= memory_budget_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    size_q      <= size_d;
    slot_q      <= slot_d;
    slot_size_q <= slot_size_d;
    free_slot_q <= free_slot_d;
    vic_slot_q  <= vic_slot_d;
    vic_age_q   <= vic_age_d;
    vic_key_q   <= vic_key_d;
    vic_size_q  <= vic_size_d;
    kind_q      <= kind_d;
    ekey_q      <= ekey_d;
    rhit_q      <= rhit_d;
    last_q      <= last_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_kind_o  = kind_q;
  assign evicted_key_o  = ekey_q;
  assign was_hit_o      = rhit_q;
  assign last_result_o  = last_q;

  // the last result of a request always leaves the block idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_result_o |-> !busy)
    else $error("last result while busy");

  // a final response always closes its request
  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_kind_o == KIND_FINAL |-> last_result_o)
    else $error("final response without last flag");

  // an empty table holds no bytes
  a_empty_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q == '0 |-> used_q == '0)
    else $error("used total nonzero with empty table");

  // no result during the lookup scan
  a_lookup_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOOKUP |-> !result_valid_o)
    else $error("result during lookup");

  // a taken request makes the block busy
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request taken but block not busy");

endmodule

FILE: test/tb.sv
// tb: self-checking bench for the size budget lru cache, with an in-bench cache predictor
// depends on sblc_pkg and the size_budget_lru_cache rtl; directed tests first, then random mixes

module tb
  import sblc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ENTRIES = DEFAULT_ENTRIES;
  // cycles with no request taken, no result and no budget write before giving up
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;
  localparam int POOL_SIZE   = 24;

  // one result as it leaves the block
  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic             hit;
    logic             last;
  } outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [KEY_W-1:0]    item_key_i = '0;
  logic [SIZE_W-1:0]   item_size_i = '0;
  logic                result_valid_o;
  logic                result_kind_o;
  logic [KEY_W-1:0]    evicted_key_o;
  logic                was_hit_o;
  logic                last_result_o;
  logic                memory_budget_we_i = 1'b0;
  logic [BUDGET_W-1:0] memory_budget_i = '0;

  // predicted cache contents, kept in step with every request taken
  logic                m_valid [NUM_ENTRIES];
  logic [KEY_W-1:0]    m_key   [NUM_ENTRIES];
  logic [SIZE_W-1:0]   m_size  [NUM_ENTRIES];
  logic [REC_W-1:0]    m_rec   [NUM_ENTRIES];
  logic [REC_W-1:0]    m_counter = '0;
  logic [31:0]         m_used = '0;
  logic [BUDGET_W-1:0] m_budget = BUDGET_RESET;

  outcome_t         outcome_q[$];   // results still owed by the block, oldest first
  int               fail_count = 0;
  int               quiet_cycles = 0;
  bit               idle_on = 1'b1; // sender gaps enabled
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  size_budget_lru_cache #(
    .ENTRIES(NUM_ENTRIES)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .item_key_i        (item_key_i),
    .item_size_i       (item_size_i),
    .result_valid_o    (result_valid_o),
    .result_kind_o     (result_kind_o),
    .evicted_key_o     (evicted_key_o),
    .was_hit_o         (was_hit_o),
    .last_result_o     (last_result_o),
    .memory_budget_we_i(memory_budget_we_i),
    .memory_budget_i   (memory_budget_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // cache predictor
  // ---------------------------------------------------------------------------

  function automatic void owe_outcome(logic kind, logic [KEY_W-1:0] key, logic hit,
                                      logic last);
    outcome_t o;
    o.kind = kind;
    o.key  = key;
    o.hit  = hit;
    o.last = last;
    outcome_q.push_back(o);
  endfunction

  // least recent valid slot by age (counter minus stamp, wrapping), ties to the
  // lowest slot; the protected slot only goes when nothing else is left
  function automatic int oldest_slot(int keep);
    int               best;
    logic [REC_W-1:0] best_age;
    logic [REC_W-1:0] age;
    best = -1;
    best_age = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (!m_valid[i] || i == keep) continue;
      age = m_counter - m_rec[i];
      if (best < 0 || age > best_age) begin
        best = i;
        best_age = age;
      end
    end
    if (best < 0 && keep >= 0 && m_valid[keep]) best = keep;
    return best;
  endfunction

  function automatic void drop_slot(int i);
    m_used = m_used - 32'(m_size[i]);
    m_valid[i] = 1'b0;
  endfunction

  // applies one request to the predicted cache and queues the results it owes
  function automatic void cache_apply_request(logic [KEY_W-1:0] key, logic [SIZE_W-1:0] size);
    int   slot;
    int   victim;
    logic hit;
    bit   self_gone;
    slot = -1;
    self_gone = 1'b0;
    m_counter = m_counter + REC_W'(1);
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (slot < 0 && m_valid[i] && m_key[i] == key) slot = i;
    end
    hit = (slot >= 0);
    if (hit) begin
      m_rec[slot] = m_counter;
    end else begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (slot < 0 && !m_valid[i]) slot = i;
      end
      // full table: oldest entry makes room and is reported first
      if (slot < 0) begin
        slot = oldest_slot(-1);
        owe_outcome(KIND_EVICT, m_key[slot], 1'b0, 1'b0);
        drop_slot(slot);
      end
      m_valid[slot] = 1'b1;
      m_key[slot]   = key;
      m_size[slot]  = size;
      m_rec[slot]   = m_counter;
      m_used        = m_used + 32'(size);
    end
    while (!self_gone && m_used > m_budget) begin
      victim = oldest_slot(slot);
      if (victim == slot) begin
        // the requested item itself goes: its notice closes the request
        owe_outcome(KIND_EVICT, m_key[victim], hit, 1'b1);
        self_gone = 1'b1;
      end else begin
        owe_outcome(KIND_EVICT, m_key[victim], 1'b0, 1'b0);
      end
      drop_slot(victim);
    end
    if (!self_gone) owe_outcome(KIND_FINAL, '0, hit, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // result checking and watchdog
  // ---------------------------------------------------------------------------

  function automatic void report_bad(string what, outcome_t want, outcome_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%s: expected kind=%0d key=%h hit=%0d last=%0d,",
               what, want.kind, want.key, want.hit, want.last,
               " got kind=%0d key=%h hit=%0d last=%0d",
               got.kind, got.key, got.hit, got.last);
    end
  endfunction

  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t want;
    if (rst_ni && result_valid_o) begin
      got.kind = result_kind_o;
      got.key  = evicted_key_o;
      got.hit  = was_hit_o;
      got.last = last_result_o;
      if (outcome_q.size() == 0) begin
        report_bad("unexpected result", '0, got);
      end else begin
        want = outcome_q.pop_front();
        if (got !== want) report_bad("result mismatch", want, got);
      end
    end
  end

  // counts cycles in which nothing at all moves
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || memory_budget_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT - 1) begin
      $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // request driving
  // ---------------------------------------------------------------------------

  // start for the coming cycle; low with a chance of about one in five while gaps are on
  function automatic logic roll_start();
    return !(idle_on && $urandom_range(0, 99) < 20);
  endfunction

  // presents one request and returns at the edge that takes it; start is left
  // high so a following request can go back to back
  task automatic send_request(input logic [KEY_W-1:0] key, input logic [SIZE_W-1:0] size);
    item_key_i  <= key;
    item_size_i <= size;
    start       <= roll_start();
    @(posedge clk_i);
    while (!(start && !busy)) begin
      start <= roll_start();
      @(posedge clk_i);
    end
    cache_apply_request(key, size);
  endtask

  // sender stops until every owed result is in and the block is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (outcome_q.size() != 0 || busy);
  endtask

  task automatic write_budget(input logic [BUDGET_W-1:0] value);
    memory_budget_we_i <= 1'b1;
    memory_budget_i    <= value;
    @(posedge clk_i);
    memory_budget_we_i <= 1'b0;
    m_budget = value;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // zero size miss, hit, then an oversize item at the key and size extremes
  // that pushes out the older entry and then itself
  task automatic test_hit_miss_extremes();
    send_request('0, '0);
    send_request('0, 24'h00_0010);
    send_request('1, '1);
    drain();
  endtask

  // sixteen small items fill the table, the seventeenth pushes out the oldest
  task automatic test_full_table();
    for (int k = 1; k <= NUM_ENTRIES + 1; k++) send_request(KEY_W'(k), 24'd1);
    drain();
  endtask

  // budget lowered between requests: a hit has to evict many entries, then
  // budget zero keeps only zero size items
  task automatic test_budget_lowered();
    write_budget(32'd5);
    send_request(32'd10, '1);
    drain();
    write_budget('0);
    send_request(32'h1234_5678, '0);
    send_request(32'h1234_5678, 24'h00_0003);
    drain();
  endtask

  // a cached item larger than a newly lowered budget evicts itself on a hit
  task automatic test_hit_self_evict();
    write_budget(BUDGET_RESET);
    send_request(32'hA5A5_A5A5, 24'd100);
    drain();
    write_budget(32'd50);
    send_request(32'hA5A5_A5A5, 24'd7);
    drain();
  endtask

  // random requests under one budget: keys mostly from a small pool so hits
  // and full table evictions are common, sizes mostly up to size_max
  task automatic test_random_mix(input logic [BUDGET_W-1:0] budget, input int count,
                                 input int size_max);
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
    write_budget(budget);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0) key = $urandom();
      else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if ($urandom_range(0, 15) == 0) size = SIZE_W'($urandom());
      else size = SIZE_W'($urandom_range(0, size_max));
      send_request(key, size);
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      m_valid[i] = 1'b0;
      m_key[i]   = '0;
      m_size[i]  = '0;
      m_rec[i]   = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_hit_miss_extremes();
    test_full_table();
    test_budget_lowered();
    test_hit_self_evict();

    test_random_mix(32'hFFFF_FFFF, 80, 255);
    // long stretch with the sender never pausing
    idle_on = 1'b0;
    test_random_mix(BUDGET_RESET, 80, 200000);
    idle_on = 1'b1;
    test_random_mix(32'($urandom_range(500, 3000)), 75, 600);
    test_random_mix('0, 40, 2);
    test_random_mix($urandom(), 60, 24'hFF_FFFF);
    test_random_mix(BUDGET_RESET, 50, 300000);

    // let any stray result show up before judging
    repeat (4 * (NUM_ENTRIES + 3)) @(posedge clk_i);
    fail_count += outcome_q.size();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
